[hdl/sse2enc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 encoder package
// Shared types, opcode constants and the instruction encoding function.
// ---------------------------------------------------------------------------
package sse2enc_pkg;

	localparam int MaxBytes  = 10;
	localparam int CountW    = $clog2(MaxBytes + 1);
	localparam int IdxW      = $clog2(MaxBytes);
	localparam int QueueDepth = 2;

	// mode codes
	localparam logic [3:0] MODE_ADDSD     = 4'd0;
	localparam logic [3:0] MODE_SUBSD     = 4'd1;
	localparam logic [3:0] MODE_MULSD     = 4'd2;
	localparam logic [3:0] MODE_DIVSD     = 4'd3;
	localparam logic [3:0] MODE_UCOMISD   = 4'd4;
	localparam logic [3:0] MODE_XORPD     = 4'd5;
	localparam logic [3:0] MODE_CVTSI2SD  = 4'd6;
	localparam logic [3:0] MODE_CVTTSD2SI = 4'd7;
	localparam logic [3:0] MODE_MOVQ      = 4'd8;

	// operand kind codes
	localparam logic [1:0] KIND_REG      = 2'd0;
	localparam logic [1:0] KIND_MEM_BASE = 2'd1;
	localparam logic [1:0] KIND_MEM_DISP = 2'd2;

	// register class codes
	localparam logic [1:0] CLS_GPR = 2'd0;
	localparam logic [1:0] CLS_XMM = 2'd1;

	// register widths
	localparam logic [1:0] WID_32 = 2'd2;
	localparam logic [1:0] WID_64 = 2'd3;

	// instruction bytes
	localparam logic [7:0] PFX_F3   = 8'hF3;
	localparam logic [7:0] PFX_66   = 8'h66;
	localparam logic [7:0] PFX_F2   = 8'hF2;
	localparam logic [7:0] ESC_0F   = 8'h0F;
	localparam logic [7:0] OPC_ADD  = 8'h58;
	localparam logic [7:0] OPC_SUB  = 8'h5C;
	localparam logic [7:0] OPC_MUL  = 8'h59;
	localparam logic [7:0] OPC_DIV  = 8'h5E;
	localparam logic [7:0] OPC_UCOM = 8'h2E;
	localparam logic [7:0] OPC_XOR  = 8'h57;
	localparam logic [7:0] OPC_CVTI = 8'h2A;
	localparam logic [7:0] OPC_CVTT = 8'h2C;
	localparam logic [7:0] OPC_7E   = 8'h7E;
	localparam logic [7:0] OPC_6E   = 8'h6E;
	localparam logic [7:0] OPC_D6   = 8'hD6;
	localparam logic [7:0] SIB_RSP  = 8'h24;
	localparam logic [3:0] REX_HI   = 4'h4;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] cls;
		logic [3:0] num;
		logic [1:0] wid;
	} opnd_t;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [CountW-1:0]        count;
		logic                     err;
	} rec_t;

	function automatic logic is_xmm(input opnd_t o);
		return (o.kind == KIND_REG) && (o.cls == CLS_XMM);
	endfunction

	function automatic logic is_gpr(input opnd_t o);
		return (o.kind == KIND_REG) && (o.cls == CLS_GPR);
	endfunction

	function automatic logic is_mem(input opnd_t o);
		return ((o.kind == KIND_MEM_BASE) || (o.kind == KIND_MEM_DISP)) &&
			(o.cls == CLS_GPR) && (o.wid == WID_64);
	endfunction

	// Build the full byte record of one instruction.
	function automatic rec_t encode(input logic [3:0] mode, input logic [1:0] cnt,
			input opnd_t ds, input opnd_t sr, input logic [31:0] disp);
		rec_t        rec;
		logic        ok;
		logic [7:0]  pre;
		logic [7:0]  opc;
		logic        w;
		logic [3:0]  regn;
		logic [3:0]  rmn;
		logic        use_mem;
		opnd_t       memop;
		opnd_t       g;
		opnd_t       x;
		logic [31:0] d;
		logic [2:0]  base;
		logic [1:0]  md;
		logic        sib;
		logic [7:0]  modrm;
		logic        rex_en;
		logic [CountW-1:0] p;

		ok      = 1'b0;
		pre     = PFX_F2;
		opc     = OPC_ADD;
		w       = 1'b0;
		regn    = ds.num;
		rmn     = sr.num;
		use_mem = 1'b0;
		memop   = sr;
		g       = ds;
		x       = sr;

		if (mode <= MODE_XORPD) begin
			ok  = is_xmm(ds) && is_xmm(sr);
			pre = (mode >= MODE_UCOMISD) ? PFX_66 : PFX_F2;
			unique case (mode)
				MODE_ADDSD:   opc = OPC_ADD;
				MODE_SUBSD:   opc = OPC_SUB;
				MODE_MULSD:   opc = OPC_MUL;
				MODE_DIVSD:   opc = OPC_DIV;
				MODE_UCOMISD: opc = OPC_UCOM;
				default:      opc = OPC_XOR;
			endcase
		end else if ((mode == MODE_CVTSI2SD) || (mode == MODE_CVTTSD2SI)) begin
			g   = (mode == MODE_CVTSI2SD) ? sr : ds;
			x   = (mode == MODE_CVTSI2SD) ? ds : sr;
			ok  = is_xmm(x) && is_gpr(g) && ((g.wid == WID_32) || (g.wid == WID_64));
			w   = (g.wid == WID_64);
			opc = (mode == MODE_CVTSI2SD) ? OPC_CVTI : OPC_CVTT;
		end else if (mode == MODE_MOVQ) begin
			priority if (is_xmm(ds) && is_xmm(sr)) begin
				ok  = 1'b1;
				pre = PFX_F3;
				opc = OPC_7E;
			end else if (is_xmm(ds) && is_gpr(sr) && (sr.wid == WID_64)) begin
				ok  = 1'b1;
				pre = PFX_66;
				w   = 1'b1;
				opc = OPC_6E;
			end else if (is_xmm(ds) && is_mem(sr)) begin
				ok      = 1'b1;
				pre     = PFX_F3;
				opc     = OPC_7E;
				use_mem = 1'b1;
			end else if (is_gpr(ds) && (ds.wid == WID_64) && is_xmm(sr)) begin
				ok   = 1'b1;
				pre  = PFX_66;
				w    = 1'b1;
				opc  = OPC_7E;
				regn = sr.num;
				rmn  = ds.num;
			end else if (is_mem(ds) && is_xmm(sr)) begin
				ok      = 1'b1;
				pre     = PFX_66;
				opc     = OPC_D6;
				regn    = sr.num;
				rmn     = ds.num;
				memop   = ds;
				use_mem = 1'b1;
			end else begin
				ok = 1'b0;
			end
		end

		ok = ok && (cnt == 2'd2);

		// memory addressing: mod, SIB and displacement size
		d    = (memop.kind == KIND_MEM_DISP) ? disp : 32'd0;
		base = rmn[2:0];
		sib  = use_mem && (base == 3'd4);
		if ((d == 32'd0) && (base != 3'd5))
			md = 2'd0;
		else if ((d[31:7] == '0) || (d[31:7] == '1))
			md = 2'd1;
		else
			md = 2'd2;
		modrm = use_mem ? {md, regn[2:0], base} : {2'b11, regn[2:0], rmn[2:0]};
		rex_en = w || regn[3] || rmn[3];

		rec.bytes = '0;
		rec.err   = 1'b0;
		rec.bytes[0] = pre;
		p = CountW'(1);
		if (rex_en) begin
			rec.bytes[p[IdxW-1:0]] = {REX_HI, w, regn[3], 1'b0, rmn[3]};
			p = p + 1'b1;
		end
		rec.bytes[p[IdxW-1:0]] = ESC_0F;
		p = p + 1'b1;
		rec.bytes[p[IdxW-1:0]] = opc;
		p = p + 1'b1;
		rec.bytes[p[IdxW-1:0]] = modrm;
		p = p + 1'b1;
		if (sib) begin
			rec.bytes[p[IdxW-1:0]] = SIB_RSP;
			p = p + 1'b1;
		end
		if (use_mem && (md == 2'd1)) begin
			rec.bytes[p[IdxW-1:0]] = d[7:0];
			p = p + 1'b1;
		end else if (use_mem && (md == 2'd2)) begin
			rec.bytes[p[IdxW-1:0]] = d[7:0];
			p = p + 1'b1;
			rec.bytes[p[IdxW-1:0]] = d[15:8];
			p = p + 1'b1;
			rec.bytes[p[IdxW-1:0]] = d[23:16];
			p = p + 1'b1;
			rec.bytes[p[IdxW-1:0]] = d[31:24];
			p = p + 1'b1;
		end
		rec.count = p;

		if (!ok) begin
			rec.bytes = '0;
			rec.count = CountW'(1);
			rec.err   = 1'b1;
		end
		return rec;
	endfunction

endpackage

[hdl/sse2enc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 encoder front end
// Accepts instruction requests, classifies the operands and builds the byte
// record that is pushed into the queue.
// ---------------------------------------------------------------------------
module sse2enc_front
	import sse2enc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [1:0]  operand_count,
	input  opnd_t       dst,
	input  opnd_t       src,
	input  logic [31:0] displacement,
	output logic        push,
	output rec_t        push_rec,
	input  logic        full
);

	logic        valid_s1;
	logic [3:0]  mode_s1;
	logic [1:0]  cnt_s1;
	opnd_t       dst_s1;
	opnd_t       src_s1;
	logic [31:0] disp_s1;
	logic        take;

	assign push     = valid_s1 && !full;
	assign in_stall = valid_s1 && full;
	assign take     = in_valid && !in_stall;
	assign push_rec = encode(mode_s1, cnt_s1, dst_s1, src_s1, disp_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the request until it moves into the queue
	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			cnt_s1  <= operand_count;
			dst_s1  <= dst;
			src_s1  <= src;
			disp_s1 <= displacement;
		end
	end

endmodule

[hdl/sse2enc_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 encoder record queue
// Short queue of encoded byte records between front and back end.
// ---------------------------------------------------------------------------
module sse2enc_fifo
	import sse2enc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t pop_rec,
	output logic empty
);

	localparam int PtrW = $clog2(QueueDepth);

	rec_t                mem_q [QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [PtrW:0]       cnt_q;

	assign full    = (cnt_q == (PtrW+1)'(QueueDepth));
	assign empty   = (cnt_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

[hdl/sse2enc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 encoder back end
// Walks the record at the queue head and sends one code byte per request.
// ---------------------------------------------------------------------------
module sse2enc_back
	import sse2enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  rec_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code_byte,
	output logic       last_byte,
	output logic       encode_error
);

	logic [IdxW-1:0] idx_q;
	logic            load;
	logic            is_last;

	assign load    = !empty && (!out_valid || !out_stall);
	assign is_last = ({1'b0, idx_q} + 1'b1) == {1'b0, head.count};
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= is_last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_byte    <= head.bytes[idx_q];
			last_byte    <= is_last;
			encode_error <= head.err;
		end
	end

endmodule

[hdl/sse2_scalar_instruction_encoder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 scalar instruction encoder
// Encodes one scalar SSE2 instruction per request into x86-64 code bytes.
// ---------------------------------------------------------------------------
// Each request carries a mode (addsd, subsd, mulsd, divsd, ucomisd, xorpd,
// cvtsi2sd, cvttsd2si, movq), an operand count and two operand descriptors;
// the block answers with the instruction bytes, one per output request, in
// order: mandatory prefix, optional REX, 0F, opcode, ModRM, then for memory
// forms an optional SIB and an optional disp8 or disp32. last_byte marks
// the final byte. An operand combination that cannot be encoded yields a
// single request with encode_error and last_byte set and code_byte zero.
// The byte serializer stays on an instruction of N bytes (1 to 10) until
// all N have been sent and takes no new instruction before then; the front
// end takes a new request every cycle while the two-entry record queue has
// room, so short instructions and output stalls are absorbed by the queue.
// When nothing stalls, the request passes through the front-end register
// and the record queue before its first byte is registered on the output.
// ---------------------------------------------------------------------------
module sse2_scalar_instruction_encoder
	import sse2enc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  mode,
	input  logic [1:0]  operand_count,
	input  logic [1:0]  dst_kind,
	input  logic [1:0]  dst_class,
	input  logic [3:0]  dst_number,
	input  logic [1:0]  dst_width,
	input  logic [1:0]  src_kind,
	input  logic [1:0]  src_class,
	input  logic [3:0]  src_number,
	input  logic [1:0]  src_width,
	input  logic signed [31:0] displacement,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  code_byte,
	output logic        last_byte,
	output logic        encode_error
);

	opnd_t dst;
	opnd_t src;
	logic  push;
	rec_t  push_rec;
	logic  full;
	logic  pop;
	rec_t  head;
	logic  empty;

	// gather the operand descriptors
	assign dst = '{kind: dst_kind, cls: dst_class, num: dst_number, wid: dst_width};
	assign src = '{kind: src_kind, cls: src_class, num: src_number, wid: src_width};

	// front: hold the request and classify it into a byte record
	sse2enc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.operand_count (operand_count),
		.dst           (dst),
		.src           (src),
		.displacement  (displacement),
		.push          (push),
		.push_rec      (push_rec),
		.full          (full)
	);

	// queue: decouple classification from byte emission
	sse2enc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (head),
		.empty    (empty)
	);

	// back: advance through the record one byte per output request
	sse2enc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_byte    (code_byte),
		.last_byte    (last_byte),
		.encode_error (encode_error)
	);

endmodule

[test/tb_sse2_scalar_instruction_encoder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SSE2 scalar instruction encoder testbench
// Feeds scalar SSE2 instructions (directed corner cases, then mostly legal
// random forms with some noise) through the encoder under bursty input and
// random output stalls. Every code byte is checked against an in-bench
// encoder model.
// ---------------------------------------------------------------------------
module tb_sse2_scalar_instruction_encoder;
	import sse2enc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] KIND_OTHER     = 2'd3;
	localparam logic [1:0] CLS_OTHER      = 2'd2;
	localparam logic [1:0] CLS_RESERVED   = 2'd3;
	localparam logic [1:0] WID_8          = 2'd0;
	localparam logic [1:0] WID_16         = 2'd1;
	localparam logic [1:0] OPERAND_PAIR   = 2'd2;
	localparam logic [1:0] OPERAND_NONE   = 2'd0;
	localparam logic [1:0] OPERAND_TRIPLE = 2'd3;
	localparam logic [3:0] MODE_FIRST_UNUSED = 4'd9;
	localparam logic [3:0] MODE_LAST_UNUSED  = 4'd15;

	localparam int RANDOM_INSNS = 480;
	localparam int HOLD_START   = 300;     // receiver cycle at which the long hold-off begins
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int TIMEOUT_NS   = 2_000_000;
	localparam int MAX_REPORTS  = 40;

	typedef struct {
		logic [3:0]  mode;
		logic [1:0]  count;
		opnd_t       dst;
		opnd_t       src;
		logic [31:0] disp;
	} insn_t;

	typedef struct {
		logic [7:0] code;
		logic       is_last;
		logic       err;
	} code_byte_t;

	typedef enum {FORM_XMM, FORM_GPR32, FORM_GPR64, FORM_MEM} form_e;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  mode = '0;
	logic [1:0]  operand_count = '0;
	logic [1:0]  dst_kind = '0;
	logic [1:0]  dst_class = '0;
	logic [3:0]  dst_number = '0;
	logic [1:0]  dst_width = '0;
	logic [1:0]  src_kind = '0;
	logic [1:0]  src_class = '0;
	logic [3:0]  src_number = '0;
	logic [1:0]  src_width = '0;
	logic signed [31:0] displacement = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  code_byte;
	logic        last_byte;
	logic        encode_error;

	insn_t        pending_insns[$];   // requests not yet offered to the block
	code_byte_t   expected_bytes[$];  // bytes the block still owes, oldest first
	insn_t        cur_insn;           // request currently on the input ports
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_cycles = 0;
	int           hold_left = 0;
	stall_style_e stall_style = STALL_NONE;
	int           mismatches = 0;
	int           insns_sent = 0;
	int           bytes_checked = 0;
	int           rejected_seen = 0;

	sse2_scalar_instruction_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.operand_count(operand_count),
		.dst_kind     (dst_kind),
		.dst_class    (dst_class),
		.dst_number   (dst_number),
		.dst_width    (dst_width),
		.src_kind     (src_kind),
		.src_class    (src_class),
		.src_number   (src_number),
		.src_width    (src_width),
		.displacement (displacement),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_byte    (code_byte),
		.last_byte    (last_byte),
		.encode_error (encode_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Operand classification, as the encoder sees it
	// -----------------------------------------------------------------------
	function automatic logic xmm_operand(input opnd_t o);
		return (o.kind == KIND_REG) && (o.cls == CLS_XMM);
	endfunction

	function automatic logic gpr_operand(input opnd_t o);
		return (o.kind == KIND_REG) && (o.cls == CLS_GPR);
	endfunction

	// Memory needs a 64-bit general purpose base
	function automatic logic mem_operand(input opnd_t o);
		return ((o.kind == KIND_MEM_BASE) || (o.kind == KIND_MEM_DISP)) &&
			(o.cls == CLS_GPR) && (o.wid == WID_64);
	endfunction

	// -----------------------------------------------------------------------
	// Encoder model: work out the bytes of one instruction and queue them
	// -----------------------------------------------------------------------
	task automatic expect_encoding(input insn_t ins);
		logic [7:0]  enc[$];
		logic        legal;
		logic [7:0]  pfx;
		logic [7:0]  opc;
		logic        rex_w;
		logic        use_mem;
		logic [3:0]  reg_n;
		logic [3:0]  rm_n;
		opnd_t       mem_op;
		logic [31:0] d;
		logic [2:0]  base;
		logic [1:0]  md;
		code_byte_t  cb;

		legal   = 1'b0;
		pfx     = PFX_F2;
		opc     = OPC_ADD;
		rex_w   = 1'b0;
		use_mem = 1'b0;
		reg_n   = ins.dst.num;
		rm_n    = ins.src.num;
		mem_op  = ins.src;

		case (ins.mode)
			MODE_ADDSD: opc = OPC_ADD;
			MODE_SUBSD: opc = OPC_SUB;
			MODE_MULSD: opc = OPC_MUL;
			MODE_DIVSD: opc = OPC_DIV;
			MODE_UCOMISD: begin
				pfx = PFX_66;
				opc = OPC_UCOM;
			end
			MODE_XORPD: begin
				pfx = PFX_66;
				opc = OPC_XOR;
			end
			MODE_CVTSI2SD: begin
				// xmm destination, 32/64-bit integer source
				opc   = OPC_CVTI;
				legal = xmm_operand(ins.dst) && gpr_operand(ins.src) &&
					(ins.src.wid >= WID_32);
				rex_w = (ins.src.wid == WID_64);
			end
			MODE_CVTTSD2SI: begin
				opc   = OPC_CVTT;
				legal = gpr_operand(ins.dst) && (ins.dst.wid >= WID_32) &&
					xmm_operand(ins.src);
				rex_w = (ins.dst.wid == WID_64);
			end
			MODE_MOVQ: begin
				if (xmm_operand(ins.dst) && xmm_operand(ins.src)) begin
					legal = 1'b1;
					pfx   = PFX_F3;
					opc   = OPC_7E;
				end else if (xmm_operand(ins.dst) && gpr_operand(ins.src) &&
						(ins.src.wid == WID_64)) begin
					legal = 1'b1;
					pfx   = PFX_66;
					rex_w = 1'b1;
					opc   = OPC_6E;
				end else if (xmm_operand(ins.dst) && mem_operand(ins.src)) begin
					legal   = 1'b1;
					pfx     = PFX_F3;
					opc     = OPC_7E;
					use_mem = 1'b1;
				end else if (gpr_operand(ins.dst) && (ins.dst.wid == WID_64) &&
						xmm_operand(ins.src)) begin
					// store form: xmm goes to the reg field
					legal = 1'b1;
					pfx   = PFX_66;
					rex_w = 1'b1;
					opc   = OPC_7E;
					reg_n = ins.src.num;
					rm_n  = ins.dst.num;
				end else if (mem_operand(ins.dst) && xmm_operand(ins.src)) begin
					legal   = 1'b1;
					pfx     = PFX_66;
					opc     = OPC_D6;
					reg_n   = ins.src.num;
					rm_n    = ins.dst.num;
					mem_op  = ins.dst;
					use_mem = 1'b1;
				end
			end
			default: legal = 1'b0;
		endcase
		// plain arithmetic forms are xmm, xmm only
		if (ins.mode <= MODE_XORPD)
			legal = xmm_operand(ins.dst) && xmm_operand(ins.src);
		if (ins.count != OPERAND_PAIR)
			legal = 1'b0;

		if (!legal) begin
			cb.code    = 8'h00;
			cb.is_last = 1'b1;
			cb.err     = 1'b1;
			expected_bytes.push_back(cb);
			return;
		end

		enc.push_back(pfx);
		if (rex_w || reg_n[3] || rm_n[3])
			enc.push_back({REX_HI, rex_w, reg_n[3], 1'b0, rm_n[3]});
		enc.push_back(ESC_0F);
		enc.push_back(opc);
		if (use_mem) begin
			// base-only kind ignores the displacement input
			d    = (mem_op.kind == KIND_MEM_DISP) ? ins.disp : 32'd0;
			base = rm_n[2:0];
			if ((d == 32'd0) && (base != 3'd5))
				md = 2'd0;
			else if (($signed(d) >= -128) && ($signed(d) <= 127))
				md = 2'd1;
			else
				md = 2'd2;
			enc.push_back({md, reg_n[2:0], base});
			if (base == 3'd4)
				enc.push_back(SIB_RSP);
			if (md == 2'd1) begin
				enc.push_back(d[7:0]);
			end else if (md == 2'd2) begin
				enc.push_back(d[7:0]);
				enc.push_back(d[15:8]);
				enc.push_back(d[23:16]);
				enc.push_back(d[31:24]);
			end
		end else begin
			enc.push_back({2'b11, reg_n[2:0], rm_n[2:0]});
		end

		foreach (enc[k]) begin
			cb.code    = enc[k];
			cb.is_last = (k == enc.size() - 1);
			cb.err     = 1'b0;
			expected_bytes.push_back(cb);
		end
	endtask

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------
	function automatic opnd_t operand_of(input logic [1:0] kind, input logic [1:0] cls,
			input logic [3:0] num, input logic [1:0] wid);
		opnd_t o;
		o.kind = kind;
		o.cls  = cls;
		o.num  = num;
		o.wid  = wid;
		return o;
	endfunction

	function automatic insn_t make_insn(input logic [3:0] m, input logic [1:0] cnt,
			input opnd_t dst, input opnd_t src, input logic [31:0] disp);
		insn_t ins;
		ins.mode  = m;
		ins.count = cnt;
		ins.dst   = dst;
		ins.src   = src;
		ins.disp  = disp;
		return ins;
	endfunction

	// Random operand of a given legal form; memory bases lean on 4 and 5,
	// which pull in SIB and the forced displacement
	function automatic opnd_t pick_operand(input form_e form);
		opnd_t o;
		o.kind = KIND_REG;
		o.cls  = CLS_GPR;
		o.num  = 4'($urandom_range(0, 15));
		o.wid  = 2'($urandom_range(0, 3));
		case (form)
			FORM_XMM:   o.cls = CLS_XMM;
			FORM_GPR32: o.wid = WID_32;
			FORM_GPR64: o.wid = WID_64;
			default: begin
				o.kind = $urandom_range(0, 1) ? KIND_MEM_DISP : KIND_MEM_BASE;
				o.wid  = WID_64;
				if ($urandom_range(0, 1))
					o.num[2:1] = 2'b10;
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// -----------------------------------------------------------------------
	// Driver: offer queued requests in bursts, predict each accepted one
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : request_driver
		insn_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// the block takes the request on the ports at this edge
			if (in_valid && !in_stall) begin
				expect_encoding(cur_insn);
				insns_sent++;
			end
			// hold a stalled request; otherwise advance or idle
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_insns.size() != 0) begin
					nxt = pending_insns.pop_front();
					cur_insn = nxt;
					mode          <= nxt.mode;
					operand_count <= nxt.count;
					dst_kind      <= nxt.dst.kind;
					dst_class     <= nxt.dst.cls;
					dst_number    <= nxt.dst.num;
					dst_width     <= nxt.dst.wid;
					src_kind      <= nxt.src.kind;
					src_class     <= nxt.src.cls;
					src_number    <= nxt.src.num;
					src_width     <= nxt.src.wid;
					displacement  <= nxt.disp;
					in_valid      <= 1'b1;
					// close the burst and schedule a gap, often none at all
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Receiver stall pattern: a randomly redrawn style, plus one long
	// hold-off so the record queue fills and the input side stalls
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : stall_pattern
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycles = 0;
			hold_left = 0;
		end else begin
			rx_cycles++;
			if (rx_cycles == HOLD_START)
				hold_left = HOLD_CYCLES;
			if (rx_cycles % 64 == 0)
				stall_style = stall_style_e'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: compare each accepted byte with the oldest expectation
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : byte_monitor
		code_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			bytes_checked++;
			if (encode_error)
				rejected_seen++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last=%0b err=%0b",
					code_byte, last_byte, encode_error));
			end else begin
				want = expected_bytes.pop_front();
				if (code_byte !== want.code)
					report_mismatch($sformatf("code_byte %02h, expected %02h",
						code_byte, want.code));
				if (last_byte !== want.is_last)
					report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
						last_byte, want.is_last, want.code));
				if (encode_error !== want.err)
					report_mismatch($sformatf("encode_error %0b, expected %0b",
						encode_error, want.err));
			end
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence: load requests, release reset, drain, judge
	// -----------------------------------------------------------------------
	initial begin : main_sequence
		insn_t it;
		int    i;

		// Directed: every mode, REX bits, all movq forms, memory corners
		pending_insns.push_back(make_insn(MODE_ADDSD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_SUBSD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd15, WID_16),
			operand_of(KIND_REG, CLS_XMM, 4'd8, WID_32), 32'd0));
		pending_insns.push_back(make_insn(MODE_MULSD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd7, WID_64),
			operand_of(KIND_REG, CLS_XMM, 4'd9, WID_64), 32'hFFFF_FFFF));
		pending_insns.push_back(make_insn(MODE_DIVSD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd3, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd12, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_UCOMISD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd8, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_XORPD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_CVTSI2SD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8),
			operand_of(KIND_REG, CLS_GPR, 4'd0, WID_32), 32'd0));
		pending_insns.push_back(make_insn(MODE_CVTSI2SD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd9, WID_8),
			operand_of(KIND_REG, CLS_GPR, 4'd12, WID_64), 32'd0));
		pending_insns.push_back(make_insn(MODE_CVTTSD2SI, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_GPR, 4'd3, WID_32),
			operand_of(KIND_REG, CLS_XMM, 4'd15, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_CVTTSD2SI, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_GPR, 4'd15, WID_64),
			operand_of(KIND_REG, CLS_XMM, 4'd10, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd4, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd13, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd11, WID_8),
			operand_of(KIND_REG, CLS_GPR, 4'd2, WID_64), 32'd0));
		// base-only [rsp]: displacement input must be ignored, SIB appears
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8),
			operand_of(KIND_MEM_BASE, CLS_GPR, 4'd4, WID_64), 32'h1234_5678));
		// base-only [rbp]: forced disp8 of zero
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8),
			operand_of(KIND_MEM_BASE, CLS_GPR, 4'd5, WID_64), 32'd0));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8),
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd13, WID_64), 32'd127));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd3, WID_8),
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd0, WID_64), 32'hFFFF_FF80));
		// longest encoding: REX, SIB and disp32
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd14, WID_8),
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd12, WID_64), 32'h8000_0000));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd5, WID_8),
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd1, WID_64), 32'h7FFF_FFFF));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_GPR, 4'd9, WID_64),
			operand_of(KIND_REG, CLS_XMM, 4'd6, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd12, WID_64),
			operand_of(KIND_REG, CLS_XMM, 4'd9, WID_8), 32'd128));
		// displacement kind with a zero value: no displacement bytes
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd3, WID_64),
			operand_of(KIND_REG, CLS_XMM, 4'd7, WID_8), 32'd0));
		// rejected encodings: unused modes, wrong counts, bad operands
		pending_insns.push_back(make_insn(MODE_FIRST_UNUSED, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_LAST_UNUSED, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_ADDSD, OPERAND_NONE,
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_XORPD, OPERAND_TRIPLE,
			operand_of(KIND_REG, CLS_XMM, 4'd0, WID_8),
			operand_of(KIND_REG, CLS_XMM, 4'd1, WID_8), 32'd0));
		pending_insns.push_back(make_insn(MODE_CVTSI2SD, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8),
			operand_of(KIND_REG, CLS_GPR, 4'd2, WID_16), 32'd0));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8),
			operand_of(KIND_MEM_DISP, CLS_GPR, 4'd6, WID_32), 32'd16));
		pending_insns.push_back(make_insn(MODE_MOVQ, OPERAND_PAIR,
			operand_of(KIND_REG, CLS_XMM, 4'd2, WID_8),
			operand_of(KIND_OTHER, CLS_OTHER, 4'd6, WID_64), 32'd0));

		// Random: mostly legal forms with random content, the rest noise
		// or legal forms with one field broken
		for (i = 0; i < RANDOM_INSNS; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				it.mode  = 4'($urandom);
				it.count = 2'($urandom);
				it.dst   = opnd_t'($urandom);
				it.src   = opnd_t'($urandom);
				it.disp  = $urandom;
			end else begin
				it.mode  = 4'($urandom_range(0, 8));
				it.count = OPERAND_PAIR;
				case ($urandom_range(0, 5))
					0:       it.disp = 32'd0;
					1:       it.disp = 32'($urandom_range(0, 255)) - 32'd128;
					2: begin
						case ($urandom_range(0, 5))
							0:       it.disp = 32'd127;
							1:       it.disp = 32'd128;
							2:       it.disp = 32'hFFFF_FF80;
							3:       it.disp = 32'hFFFF_FF7F;
							4:       it.disp = 32'h7FFF_FFFF;
							default: it.disp = 32'h8000_0000;
						endcase
					end
					default: it.disp = $urandom;
				endcase
				case (it.mode)
					MODE_CVTSI2SD: begin
						it.dst = pick_operand(FORM_XMM);
						it.src = pick_operand($urandom_range(0, 1) ? FORM_GPR64 : FORM_GPR32);
					end
					MODE_CVTTSD2SI: begin
						it.dst = pick_operand($urandom_range(0, 1) ? FORM_GPR64 : FORM_GPR32);
						it.src = pick_operand(FORM_XMM);
					end
					MODE_MOVQ: begin
						case ($urandom_range(0, 4))
							0: begin
								it.dst = pick_operand(FORM_XMM);
								it.src = pick_operand(FORM_XMM);
							end
							1: begin
								it.dst = pick_operand(FORM_XMM);
								it.src = pick_operand(FORM_GPR64);
							end
							2: begin
								it.dst = pick_operand(FORM_XMM);
								it.src = pick_operand(FORM_MEM);
							end
							3: begin
								it.dst = pick_operand(FORM_GPR64);
								it.src = pick_operand(FORM_XMM);
							end
							default: begin
								it.dst = pick_operand(FORM_MEM);
								it.src = pick_operand(FORM_XMM);
							end
						endcase
					end
					default: begin
						it.dst = pick_operand(FORM_XMM);
						it.src = pick_operand(FORM_XMM);
					end
				endcase
				// break roughly one legal form in ten
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: begin
							it.count = 2'($urandom_range(0, 2));
							if (it.count == OPERAND_PAIR)
								it.count = OPERAND_TRIPLE;
						end
						1:       it.dst.kind = KIND_OTHER;
						2:       it.src.cls = $urandom_range(0, 1) ? CLS_OTHER : CLS_RESERVED;
						default: it.dst.wid = $urandom_range(0, 1) ? WID_8 : WID_16;
					endcase
				end
			end
			pending_insns.push_back(it);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all requests taken, then all bytes back, then settle
		while (pending_insns.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d instructions encoded, %0d code bytes checked, %0d rejected",
			insns_sent, bytes_checked, rejected_seen);
		$display("Summary: all modes and movq forms, SIB/disp8/disp32 addressing, %0d-cycle %s",
			HOLD_CYCLES, "output hold-off");
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: the slowest legal run is far below this
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timeout with %0d bytes still owed", expected_bytes.size());
		$display("Verification failed");
		$finish;
	end

endmodule

[sse2_scalar_instruction_encoder.f]
hdl/sse2enc_pkg.sv
hdl/sse2enc_front.sv
hdl/sse2enc_fifo.sv
hdl/sse2enc_back.sv
hdl/sse2_scalar_instruction_encoder.sv
test/tb_sse2_scalar_instruction_encoder.sv
